// ===== hdl/pvp_pkg.sv =====
// package for the perspective vertex projection unit
// payload structs, register indexes and fixed-point constants; no dependencies
package pvp_pkg;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] screen_x;
      logic signed [15:0] screen_y;
      logic               near_clamped;
      logic               saturated;
   } rsp_type;

   typedef enum logic [2:0] {
      REG_CAM_POS_X = 3'd0,
      REG_CAM_POS_Y = 3'd1,
      REG_CAM_POS_Z = 3'd2,
      REG_YAW_COS   = 3'd3,
      REG_YAW_SIN   = 3'd4,
      REG_PITCH_COS = 3'd5,
      REG_PITCH_SIN = 3'd6,
      REG_NONE      = 3'd7
   } reg_index_type;

   localparam int DEPTH_W = 53;
   // 0.001 and 0.1 in q23.30
   localparam logic signed [DEPTH_W-1:0] NEAR_LIMIT = 53'sd1073741;
   localparam logic signed [DEPTH_W-1:0] NEAR_VALUE = 53'sd107374182;
   localparam logic signed [15:0]        TRIG_ONE   = 16'sd16384;
   localparam int QUOT_W = 18;

endpackage

// ===== hdl/perspective_vertex_project_unit.sv =====
// perspective vertex projection unit: camera offset, yaw and pitch rotation,
// pipelined restoring divide and saturation; depends on pvp_pkg
//
//   channel  ports                         direction  transfer
//   input    start, busy, req_data         in         start high and busy low
//   result   rsp_valid, rsp_data           out        one-cycle strobe
//   config   csr_we, csr_index, csr_wdata  in         write enable high
//
// a transaction enters every cycle; its result passes through seven arithmetic stages,
// eighteen divide steps and the output register
// busy stays low: the pipeline always advances since the receiver cannot stall
// reset clears the valid bits and loads the camera registers with their defaults
module perspective_vertex_project_unit
   import pvp_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  req_type       req_data,
   output logic          rsp_valid,
   output rsp_type       rsp_data,
   input  logic          csr_we,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_wdata
);

   localparam int WB    = $clog2(SCREEN_WIDTH + 1);
   localparam int HB    = $clog2(SCREEN_HEIGHT + 1);
   localparam int XS_W  = 14 + WB + 1;
   localparam int HS_W  = HB + 1;
   localparam int NX_W  = 36 + XS_W;
   localparam int NY_W  = DEPTH_W + HS_W;
   localparam int NW    = (NX_W > NY_W) ? NX_W : NY_W;
   localparam int SH_W  = DEPTH_W + QUOT_W;
   localparam int CW    = ((NW > SH_W) ? NW : SH_W) + 1;
   localparam int STEPS = QUOT_W;

   localparam logic signed [XS_W-1:0] XSCALE = XS_W'(16384 * SCREEN_WIDTH);
   localparam logic signed [HS_W-1:0] HSCALE = HS_W'(SCREEN_HEIGHT);

   // configuration registers
   logic signed [31:0] cam_x_ff, cam_y_ff, cam_z_ff;
   logic signed [15:0] yc_ff, ys_ff, pc_ff, ps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff <= '0;
         cam_y_ff <= '0;
         cam_z_ff <= '0;
         yc_ff    <= TRIG_ONE;
         ys_ff    <= '0;
         pc_ff    <= TRIG_ONE;
         ps_ff    <= '0;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_CAM_POS_X: cam_x_ff <= csr_wdata;
            REG_CAM_POS_Y: cam_y_ff <= csr_wdata;
            REG_CAM_POS_Z: cam_z_ff <= csr_wdata;
            REG_YAW_COS:   yc_ff    <= csr_wdata[15:0];
            REG_YAW_SIN:   ys_ff    <= csr_wdata[15:0];
            REG_PITCH_COS: pc_ff    <= csr_wdata[15:0];
            REG_PITCH_SIN: ps_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic accept;
   assign accept = start & ~busy;

   // valid bits: stages a..g
   logic [6:0] vld_ff;

   // stage a: camera offset
   logic signed [32:0] a_dx_ff, a_dy_ff, a_dz_ff;
   // stage b: yaw products
   logic signed [48:0] b_p0_ff, b_p1_ff, b_p2_ff, b_p3_ff;
   logic signed [32:0] b_dz_ff;
   // stage c: yaw sums
   logic signed [35:0] c_xa_ff, c_ya_ff;
   logic signed [32:0] c_dz_ff;
   // stage d: pitch products
   logic signed [51:0] d_p4_ff, d_p6_ff;
   logic signed [48:0] d_p5_ff, d_p7_ff;
   logic signed [35:0] d_ya_ff;
   // stage e: pitch sums
   logic signed [DEPTH_W-1:0] e_depth_ff, e_zv_ff;
   logic signed [35:0]        e_ya_ff;
   // stage f: near clamp and numerators
   logic signed [NX_W-1:0]    f_nx_ff;
   logic signed [NY_W-1:0]    f_ny_ff;
   logic [DEPTH_W-1:0]        f_den_ff;
   logic                      f_near_ff;
   // stage g: magnitudes and result signs
   logic [NW-1:0]             g_mag_ff [0:1];
   logic [1:0]                g_neg_ff;
   logic [DEPTH_W-1:0]        g_den_ff;
   logic                      g_near_ff;

   logic signed [49:0]     c_sum0_in, c_sum1_in;
   logic signed [DEPTH_W-1:0] e_depth_in, e_zv_in, f_den_in;
   logic                   f_near_in;
   logic signed [NW-1:0]   g_nx_in, g_ny_in;

   assign c_sum0_in  = 50'(b_p0_ff) + 50'(b_p1_ff);
   assign c_sum1_in  = 50'(b_p2_ff) - 50'(b_p3_ff);
   assign e_depth_in = DEPTH_W'(d_p4_ff) - DEPTH_W'(d_p5_ff);
   assign e_zv_in    = DEPTH_W'(d_p6_ff) + DEPTH_W'(d_p7_ff);
   assign f_near_in  = (e_depth_ff <= NEAR_LIMIT);
   assign f_den_in   = f_near_in ? NEAR_VALUE : e_depth_ff;
   assign g_nx_in    = NW'(f_nx_ff);
   assign g_ny_in    = NW'(f_ny_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[5:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      a_dx_ff <= 33'(req_data.point_x) - 33'(cam_x_ff);
      a_dy_ff <= 33'(req_data.point_y) - 33'(cam_y_ff);
      a_dz_ff <= 33'(req_data.point_z) - 33'(cam_z_ff);

      b_p0_ff <= yc_ff * a_dx_ff;
      b_p1_ff <= ys_ff * a_dy_ff;
      b_p2_ff <= yc_ff * a_dy_ff;
      b_p3_ff <= ys_ff * a_dx_ff;
      b_dz_ff <= a_dz_ff;

      c_xa_ff <= 36'(c_sum0_in >>> 14);
      c_ya_ff <= 36'(c_sum1_in >>> 14);
      c_dz_ff <= b_dz_ff;

      d_p4_ff <= pc_ff * c_xa_ff;
      d_p5_ff <= ps_ff * c_dz_ff;
      d_p6_ff <= ps_ff * c_xa_ff;
      d_p7_ff <= pc_ff * c_dz_ff;
      d_ya_ff <= c_ya_ff;

      e_depth_ff <= e_depth_in;
      e_zv_ff    <= e_zv_in;
      e_ya_ff    <= d_ya_ff;

      f_nx_ff   <= e_ya_ff * XSCALE;
      f_ny_ff   <= e_zv_ff * HSCALE;
      f_den_ff  <= f_den_in;
      f_near_ff <= f_near_in;

      g_mag_ff[0] <= f_nx_ff[NX_W-1] ? NW'(-g_nx_in) : NW'(g_nx_in);
      g_mag_ff[1] <= f_ny_ff[NY_W-1] ? NW'(-g_ny_in) : NW'(g_ny_in);
      g_neg_ff[0] <= ~f_nx_ff[NX_W-1] & (f_nx_ff != '0);
      g_neg_ff[1] <= f_ny_ff[NY_W-1];
      g_den_ff    <= f_den_ff;
      g_near_ff   <= f_near_ff;
   end

   // restoring divide, one quotient bit per stage, two lanes
   logic [NW-1:0]      dv_rem_ff  [0:STEPS-1][0:1];
   logic [QUOT_W-1:0]  dv_quot_ff [0:STEPS-1][0:1];
   logic [DEPTH_W-1:0] dv_den_ff  [0:STEPS-1];
   logic [1:0]         dv_neg_ff  [0:STEPS-1];
   logic               dv_near_ff [0:STEPS-1];
   logic [STEPS-1:0]   dv_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff <= '0;
      end else begin
         dv_vld_ff <= {dv_vld_ff[STEPS-2:0], vld_ff[6]};
      end
   end

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      logic [NW-1:0]      rem_src  [0:1];
      logic [QUOT_W-1:0]  quot_src [0:1];
      logic [DEPTH_W-1:0] den_src;
      logic [CW-1:0]      shifted;

      if (j == 0) begin : g_first
         always_comb begin
            rem_src[0]  = g_mag_ff[0];
            rem_src[1]  = g_mag_ff[1];
            quot_src[0] = '0;
            quot_src[1] = '0;
            den_src     = g_den_ff;
         end
         always_ff @(posedge clock) begin
            dv_neg_ff[j]  <= g_neg_ff;
            dv_near_ff[j] <= g_near_ff;
         end
      end else begin : g_next
         always_comb begin
            rem_src[0]  = dv_rem_ff[j-1][0];
            rem_src[1]  = dv_rem_ff[j-1][1];
            quot_src[0] = dv_quot_ff[j-1][0];
            quot_src[1] = dv_quot_ff[j-1][1];
            den_src     = dv_den_ff[j-1];
         end
         always_ff @(posedge clock) begin
            dv_neg_ff[j]  <= dv_neg_ff[j-1];
            dv_near_ff[j] <= dv_near_ff[j-1];
         end
      end

      assign shifted = CW'(den_src) << (STEPS - 1 - j);

      for (genvar k = 0; k < 2; k++) begin : g_lane
         logic          fits;
         logic [CW-1:0] diff;
         assign fits = (CW'(rem_src[k]) >= shifted);
         assign diff = CW'(rem_src[k]) - shifted;
         always_ff @(posedge clock) begin
            dv_rem_ff[j][k]  <= fits ? diff[NW-1:0] : rem_src[k];
            dv_quot_ff[j][k] <= quot_src[k] | (QUOT_W'(fits) << (STEPS - 1 - j));
         end
      end

      always_ff @(posedge clock) begin
         dv_den_ff[j] <= den_src;
      end
   end

   // sign and saturation
   logic signed [15:0] res_in [0:1];
   logic [1:0]         sat_in;

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         if (dv_neg_ff[STEPS-1][k]) begin
            sat_in[k] = dv_quot_ff[STEPS-1][k] > QUOT_W'(32768);
            res_in[k] = sat_in[k] ? -16'sd32768 : 16'(-dv_quot_ff[STEPS-1][k]);
         end else begin
            sat_in[k] = dv_quot_ff[STEPS-1][k] > QUOT_W'(32767);
            res_in[k] = sat_in[k] ? 16'sd32767 : 16'(dv_quot_ff[STEPS-1][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= dv_vld_ff[STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_data.screen_x     <= res_in[0];
      rsp_data.screen_y     <= res_in[1];
      rsp_data.near_clamped <= dv_near_ff[STEPS-1];
      rsp_data.saturated    <= |sat_in;
   end

endmodule
